@@ sv/bitmap_frame_allocator_top_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the page frame allocator
// Clocked implication checks, disabled while the active-high reset is high.
// ---------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define BFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bfa_pkg.sv @@
// ---------------------------------------------------------------------------
// Page frame allocator package
// Sizes, request and status codes, and the controller state type.
// ---------------------------------------------------------------------------
package bfa_pkg;

  localparam int BITMAP_WORDS = 64;
  localparam int WORD_BITS    = 64;
  localparam int WORD_ADDR_W  = $clog2(BITMAP_WORDS);
  localparam int BIT_IDX_W    = $clog2(WORD_BITS);
  localparam int FRAME_W      = 12;
  localparam int COUNT_W      = 13;
  localparam int TOTAL_FRAMES = BITMAP_WORDS * WORD_BITS;

  localparam logic [COUNT_W-1:0] TOTAL_FRAMES_C = COUNT_W'(TOTAL_FRAMES);
  localparam logic [COUNT_W-1:0] FRAME_LIMIT_RESET = 13'h1000;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_MARK  = 2'd2;
  localparam logic [1:0] REQ_QUERY = 2'd3;

  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_NONE_FREE = 2'd1;
  localparam logic [1:0] STAT_NO_CHANGE = 2'd2;
  localparam logic [1:0] STAT_RANGE     = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } bfa_state_t;

endpackage

@@ sv/bitmap_frame_allocator_top.sv @@
// ---------------------------------------------------------------------------
// First-fit page frame allocator
// Used/free bitmap in a word memory with a per-word full flag and used count.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ group: s_tuser carries the request kind and
//   s_tdata the frame number. Each request yields one result on the m_ group.
//   The frame limit is written on the cfg_ channel; the user must write it
//   only while idle; the block does not enforce this. A request is read
//   from the bitmap memory at its accept edge; the execute state then
//   modifies the word, writes it back and loads the result register once
//   the output register is free. A new request is taken only after that.
//   The lowest non-full word is picked from the full flags at the accept
//   edge; the lowest free bit in it is picked from the memory read data.
//   A result that the receiver stalls stays in the output register; the
//   next request is still taken and waits in its execute cycle until the
//   output register is free.
//   Reset clears the per-word valid and full flags at once, so the whole
//   bitmap reads as free as soon as reset ends; the used count clears to zero
//   and the frame limit returns to 4096.
// ---------------------------------------------------------------------------
`include "bitmap_frame_allocator_top_assert.svh"

module bitmap_frame_allocator_top
  import bfa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [COUNT_W-1:0]  cfg_data,   // frame_limit
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [15:0]         s_tdata,    // [11:0] frame_index
  input  logic [1:0]          s_tuser,    // [1:0] req_type
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata     // [11:0] result_frame, [13:12] status,
                                          // [14] frame_used, [27:15] used_total
);

  logic [WORD_BITS-1:0]   mem [BITMAP_WORDS];
  logic [WORD_BITS-1:0]   mem_q;
  logic [BITMAP_WORDS-1:0] word_valid;
  logic [BITMAP_WORDS-1:0] word_full;
  logic                   rd_valid;

  bfa_state_t state, state_next;
  logic [COUNT_W-1:0]     frame_limit;
  logic [COUNT_W-1:0]     used_count;
  logic [COUNT_W-1:0]     used_count_next;

  logic [1:0]             op_req;
  logic [FRAME_W-1:0]     op_frame;
  logic [WORD_ADDR_W-1:0] op_word;
  logic                   op_word_found;

  logic                   accept;
  logic                   exec_go;

  logic                   free_found;
  logic [WORD_ADDR_W-1:0] free_word;
  logic [WORD_ADDR_W-1:0] rd_addr;

  logic [WORD_BITS-1:0]   cur_word;
  logic [WORD_BITS-1:0]   new_word;
  logic                   bit_found;
  logic [BIT_IDX_W-1:0]   bit_free;
  logic [FRAME_W-1:0]     alloc_frame;
  logic [COUNT_W-1:0]     lim;
  logic                   cur_bit;
  logic                   wr_en;
  logic [FRAME_W-1:0]     res_frame;
  logic [1:0]             res_status;
  logic                   res_used;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= FRAME_LIMIT_RESET;
    end else if (cfg_valid) begin
      frame_limit <= cfg_data;
    end
  end

  // Lowest word that is not full.
  always_comb begin
    free_found = 1'b0;
    free_word  = '0;
    for (int i = BITMAP_WORDS - 1; i >= 0; i--) begin
      if (!word_full[i]) begin
        free_found = 1'b1;
        free_word  = WORD_ADDR_W'(i);
      end
    end
  end

  assign rd_addr = (s_tuser == REQ_ALLOC) ? free_word
                                          : s_tdata[FRAME_W-1:BIT_IDX_W];

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (s_tvalid) state_next = S_EXEC;
      S_EXEC:  if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_tready = 1'b0;
    exec_go  = 1'b0;
    case (state)
      S_IDLE:  s_tready = 1'b1;
      S_EXEC:  exec_go  = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_req        <= s_tuser;
      op_frame      <= s_tdata[FRAME_W-1:0];
      op_word       <= rd_addr;
      op_word_found <= free_found;
    end
  end

  // Bitmap memory: read at the accept edge, written back in the execute cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q <= mem[rd_addr];
    end
    if (exec_go && wr_en) begin
      mem[op_word] <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      word_full  <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (accept) begin
        rd_valid <= word_valid[rd_addr];
      end
      if (exec_go && wr_en) begin
        word_valid[op_word] <= 1'b1;
        word_full[op_word]  <= &new_word;
      end
    end
  end

  assign cur_word = rd_valid ? mem_q : '0;

  // Lowest clear bit of the word read.
  always_comb begin
    bit_found = 1'b0;
    bit_free  = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!cur_word[i]) begin
        bit_found = 1'b1;
        bit_free  = BIT_IDX_W'(i);
      end
    end
  end

  assign alloc_frame = {op_word, bit_free};
  assign lim         = (frame_limit > TOTAL_FRAMES_C) ? TOTAL_FRAMES_C : frame_limit;
  assign cur_bit     = cur_word[op_frame[BIT_IDX_W-1:0]];

  always_comb begin
    new_word        = cur_word;
    wr_en           = 1'b0;
    used_count_next = used_count;
    res_frame       = op_frame;
    res_status      = STAT_DONE;
    res_used        = 1'b0;
    if (op_req == REQ_ALLOC) begin
      if ((used_count < lim) && op_word_found && bit_found &&
          ({1'b0, alloc_frame} < lim)) begin
        new_word[bit_free] = 1'b1;
        wr_en              = 1'b1;
        used_count_next    = used_count + COUNT_W'(1);
        res_frame          = alloc_frame;
        res_used           = 1'b1;
      end else begin
        res_status = STAT_NONE_FREE;
        res_frame  = '0;
      end
    end else if ({1'b0, op_frame} >= lim) begin
      res_status = STAT_RANGE;
    end else begin
      case (op_req)
        REQ_FREE: begin
          if (cur_bit) begin
            new_word[op_frame[BIT_IDX_W-1:0]] = 1'b0;
            wr_en = 1'b1;
            if (used_count != '0) used_count_next = used_count - COUNT_W'(1);
          end else begin
            res_status = STAT_NO_CHANGE;
          end
        end
        REQ_MARK: begin
          if (!cur_bit) begin
            new_word[op_frame[BIT_IDX_W-1:0]] = 1'b1;
            wr_en           = 1'b1;
            used_count_next = used_count + COUNT_W'(1);
          end else begin
            res_status = STAT_NO_CHANGE;
          end
          res_used = 1'b1;
        end
        default: res_used = cur_bit;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (exec_go) begin
        used_count <= used_count_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      m_tdata <= {4'b0, used_count_next, res_used, res_status, res_frame};
    end
  end

  `BFA_ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == S_EXEC,
    "accepted request did not enter execute")
  `BFA_ASSERT_NEXT(a_exec_result, clk, rst, exec_go, m_tvalid,
    "execute cycle did not load a result")
  `BFA_ASSERT_NEXT(a_stall_hold, clk, rst, (state == S_EXEC) && !exec_go,
    (state == S_EXEC) && m_tvalid, "stalled execute left its state")
  `BFA_ASSERT_NEXT(a_write_valid, clk, rst, exec_go && wr_en,
    word_valid[$past(op_word)], "written bitmap word not marked valid")
  `BFA_ASSERT_NOW(a_count_range, clk, rst, exec_go,
    used_count_next <= TOTAL_FRAMES_C, "used count above frame total")

endmodule

@@ verif/tb_top.sv @@
// ---------------------------------------------------------------------------
// Page frame allocator testbench
// Drives allocate, free, mark-used and query requests under several frame
// limits, predicts every result from a bitmap model of its own and checks
// each result field by field, with random idling on both stream sides.
// ---------------------------------------------------------------------------
module tb_top;
  import bfa_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [1:0]         status;
    logic               in_use;
    logic [COUNT_W-1:0] total;
  } frame_outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [15:0]        s_tdata = '0;   // [11:0] frame_index
  logic [1:0]         s_tuser = '0;   // [1:0] req_type
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [31:0]        m_tdata;        // [11:0] result_frame, [13:12] status,
                                      // [14] frame_used, [27:15] used_total

  // Model of the allocator state.
  logic [WORD_BITS-1:0] model_bitmap [BITMAP_WORDS];
  logic [COUNT_W-1:0]   model_used;
  logic [COUNT_W-1:0]   model_limit;

  frame_outcome_t expected_outcomes [$];
  int             error_count  = 0;
  int             quiet_cycles = 0;
  bit             steady_flow  = 1'b0;

  bitmap_frame_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one request to the model and returns the result it must give.
  function automatic frame_outcome_t predict_outcome(input logic [1:0] kind,
                                                     input logic [FRAME_W-1:0] frame);
    int unsigned    lim;
    int unsigned    pick;
    logic           cur;
    frame_outcome_t r;
    lim = (model_limit < TOTAL_FRAMES) ? model_limit : TOTAL_FRAMES;
    r.frame  = frame;
    r.status = STAT_DONE;
    r.in_use = 1'b0;
    if (kind == REQ_ALLOC) begin
      // First fit over words then bits is simply the lowest clear frame.
      pick = 0;
      while (pick < lim && model_bitmap[pick / WORD_BITS][pick % WORD_BITS])
        pick++;
      if (model_used >= lim || pick >= lim) begin
        r.status = STAT_NONE_FREE;
        r.frame  = '0;
      end else begin
        model_bitmap[pick / WORD_BITS][pick % WORD_BITS] = 1'b1;
        model_used++;
        r.frame  = FRAME_W'(pick);
        r.in_use = 1'b1;
      end
    end else if (frame >= lim) begin
      r.status = STAT_RANGE;
    end else begin
      cur = model_bitmap[frame / WORD_BITS][frame % WORD_BITS];
      case (kind)
        REQ_FREE: begin
          if (cur) begin
            model_bitmap[frame / WORD_BITS][frame % WORD_BITS] = 1'b0;
            if (model_used != 0)
              model_used--;
          end else begin
            r.status = STAT_NO_CHANGE;
          end
        end
        REQ_MARK: begin
          if (!cur) begin
            model_bitmap[frame / WORD_BITS][frame % WORD_BITS] = 1'b1;
            model_used++;
          end else begin
            r.status = STAT_NO_CHANGE;
          end
          r.in_use = 1'b1;
        end
        default: r.in_use = cur;
      endcase
    end
    r.total = model_used;
    return r;
  endfunction

  task automatic flag_error(input string what, input int unsigned want,
                            input int unsigned got);
    error_count++;
    if (error_count <= REPORT_MAX)
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  // One process follows every transfer: result checks, limit writes and
  // request predictions, in that order.
  always @(posedge clk) begin
    frame_outcome_t want;
    if (rst) begin
      for (int i = 0; i < BITMAP_WORDS; i++)
        model_bitmap[i] = '0;
      model_used  = '0;
      model_limit = FRAME_LIMIT_RESET;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_outcomes.size() == 0) begin
          flag_error("result with nothing pending", 0, m_tdata);
        end else begin
          want = expected_outcomes.pop_front();
          if (m_tdata[11:0] !== want.frame)
            flag_error("result_frame", want.frame, m_tdata[11:0]);
          if (m_tdata[13:12] !== want.status)
            flag_error("status", want.status, m_tdata[13:12]);
          if (m_tdata[14] !== want.in_use)
            flag_error("frame_used", want.in_use, m_tdata[14]);
          if (m_tdata[27:15] !== want.total)
            flag_error("used_total", want.total, m_tdata[27:15]);
        end
      end
      if (cfg_valid && cfg_ready)
        model_limit = cfg_data;
      if (s_tvalid && s_tready)
        expected_outcomes.push_back(predict_outcome(s_tuser, s_tdata[FRAME_W-1:0]));
    end
  end

  always @(posedge clk) begin
    m_tready <= !rst && (steady_flow || $urandom_range(99) >= 31);
  end

  // Ends the run when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [1:0] kind, input logic [FRAME_W-1:0] frame);
    while (!steady_flow && $urandom_range(99) < 31) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'b0, frame};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_outcomes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_limit(input logic [COUNT_W-1:0] value);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Relies on the reset limit of 4096: frame 4095 must be in range.
  task automatic test_reset_defaults();
    send_request(REQ_QUERY, 12'd0);
    send_request(REQ_QUERY, 12'd4095);
    send_request(REQ_FREE,  12'd7);
    send_request(REQ_MARK,  12'd4095);
    send_request(REQ_MARK,  12'd4095);
    send_request(REQ_ALLOC, 12'hFFF);
    send_request(REQ_ALLOC, 12'd0);
    send_request(REQ_FREE,  12'd0);
    send_request(REQ_ALLOC, 12'h555);
    send_request(REQ_FREE,  12'd4095);
    send_request(REQ_QUERY, 12'd4095);
  endtask

  task automatic test_limit_extremes();
    write_frame_limit(13'd0);
    send_request(REQ_ALLOC, 12'hAAA);
    send_request(REQ_QUERY, 12'd0);
    send_request(REQ_MARK,  12'd4095);
    send_request(REQ_FREE,  12'd1);
    // Frame 1 stays set and counted but is now out of reach.
    write_frame_limit(13'd1);
    send_request(REQ_ALLOC, 12'd0);
    send_request(REQ_QUERY, 12'd1);
    send_request(REQ_FREE,  12'd0);
    send_request(REQ_ALLOC, 12'd0);
    write_frame_limit(13'd4095);
    send_request(REQ_MARK,  12'd4095);
    send_request(REQ_MARK,  12'd4094);
    write_frame_limit(FRAME_LIMIT_RESET);
    send_request(REQ_QUERY, 12'd4095);
    send_request(REQ_FREE,  12'd4094);
  endtask

  // Allocates past a limit that ends inside the first word, then frees all.
  task automatic test_fill_and_empty();
    write_frame_limit(13'd40);
    repeat (42)
      send_request(REQ_ALLOC, FRAME_W'($urandom_range(4095)));
    for (int f = 0; f < 40; f++)
      send_request(REQ_FREE, FRAME_W'(f));
  endtask

  task automatic run_random_phase(input logic [COUNT_W-1:0] limit, input int count);
    int unsigned        lim;
    int unsigned        roll;
    logic [1:0]         kind;
    logic [FRAME_W-1:0] frame;
    write_frame_limit(limit);
    lim = (limit < TOTAL_FRAMES) ? limit : TOTAL_FRAMES;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 40)
        kind = REQ_ALLOC;
      else if (roll < 62)
        kind = REQ_FREE;
      else if (roll < 80)
        kind = REQ_MARK;
      else
        kind = REQ_QUERY;
      case ($urandom_range(3))
        0: frame = FRAME_W'($urandom_range(4095));
        1: frame = (lim == 0) ? '0 : FRAME_W'($urandom_range(lim - 1));
        // Around the limit; wraps to the top frame when the limit is zero.
        2: frame = FRAME_W'(lim + $urandom_range(2) - 1);
        // First fit keeps the low frames busy, so these mostly hit used ones.
        default: frame = FRAME_W'($urandom_range(model_used + 4));
      endcase
      send_request(kind, frame);
      if ($urandom_range(49) == 0)
        wait_for_results();
    end
  endtask

  task automatic test_random_traffic();
    // Small limits first: frames taken under large limits would stay counted.
    run_random_phase(13'd1, 60);
    run_random_phase(13'd0, 30);
    run_random_phase(13'd64, 150);
    run_random_phase(13'd65, 150);
    run_random_phase(13'd130, 150);
    run_random_phase(COUNT_W'($urandom_range(300, 2)), 150);
    run_random_phase(13'd4095, 150);
    steady_flow = 1'b1;
    run_random_phase(FRAME_LIMIT_RESET, 250);
    steady_flow = 1'b0;
    run_random_phase(COUNT_W'($urandom_range(4096)), 150);
    run_random_phase(FRAME_LIMIT_RESET, 150);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_limit_extremes();
    test_fill_and_empty();
    test_random_traffic();
    wait_for_results();
    if (error_count == 0 && expected_outcomes.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/bfa_pkg.sv
sv/bitmap_frame_allocator_top.sv
verif/tb_top.sv
